[src/fdp_pkg.sv]
// Shared types and constants for the framed decimal field parser.
package fdp_pkg;

	localparam int NUM_FIELDS  = 5;
	localparam int VALUE_W     = 10;
	localparam int TOTAL_W     = 13;
	localparam int FCNT_W      = 3;
	localparam int DCNT_W      = 2;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 64;

	localparam logic [7:0] CH_START = 8'h53;  // 'S'
	localparam logic [7:0] CH_END   = 8'h54;  // 'T'
	localparam logic [7:0] CH_SEP   = 8'h2C;  // ','
	localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
	localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

	localparam logic [FCNT_W-1:0] FIELDS_FULL = FCNT_W'(NUM_FIELDS);
	localparam logic [FCNT_W-1:0] FIELDS_LAST = FCNT_W'(NUM_FIELDS - 1);

	typedef enum logic {
		ST_IDLE,
		ST_FRAME
	} fsm_state_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value_a;
		logic [VALUE_W-1:0] value_b;
		logic [VALUE_W-1:0] value_c;
		logic [VALUE_W-1:0] value_d;
		logic [VALUE_W-1:0] value_e;
		logic [TOTAL_W-1:0] field_total;
	} result_t;

	typedef struct packed {
		logic              emit;
		logic              in_frame;
		logic [FCNT_W-1:0] fields_taken;
	} core_stat_t;

endpackage

[src/fdp_core.sv]
// Frame parser: state, digit accumulate, field store and result build.
module fdp_core
	import fdp_pkg::*;
#(
	parameter int MAX_DIGITS = 3
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid,
	input  logic       step,
	input  logic [7:0] rx_byte,
	output result_t    result,
	output core_stat_t stat
);

	localparam logic [DCNT_W-1:0] MaxDig = DCNT_W'(MAX_DIGITS);

	fsm_state_t         state_q, state_d;
	logic [FCNT_W-1:0]  fields_q, fields_d;
	logic [DCNT_W-1:0]  digits_q, digits_d;
	logic [VALUE_W-1:0] accum_q, accum_d;
	logic [VALUE_W-1:0] store_q [NUM_FIELDS];
	logic               store_we;
	logic               emit;

	logic               is_start, is_end, is_sep, is_digit, can_close;
	logic [3:0]         digit;
	logic [13:0]        mac;

	assign is_start  = rx_byte == CH_START;
	assign is_end    = rx_byte == CH_END;
	assign is_sep    = rx_byte == CH_SEP;
	assign is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign digit     = 4'(rx_byte - CH_ZERO);
	assign can_close = (digits_q != '0) && (fields_q < FIELDS_FULL);
	assign mac       = 14'({accum_q, 3'b000}) + 14'({accum_q, 1'b0}) + 14'(digit);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (is_start) state_d = ST_FRAME;
			end
			ST_FRAME: begin
				if (!is_sep && !is_digit) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		fields_d = fields_q;
		digits_d = digits_q;
		accum_d  = accum_q;
		store_we = 1'b0;
		emit     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (is_start) begin
					fields_d = '0;
					digits_d = '0;
					accum_d  = '0;
				end
			end
			ST_FRAME: begin
				if (is_end) begin
					emit = (fields_q == FIELDS_FULL) ||
						((fields_q == FIELDS_LAST) && (digits_q != '0));
					fields_d = '0;
					digits_d = '0;
					accum_d  = '0;
				end else if (is_sep) begin
					if (can_close) begin
						store_we = 1'b1;
						fields_d = fields_q + 1'b1;
						digits_d = '0;
						accum_d  = '0;
					end
				end else if (is_digit) begin
					if (digits_q < MaxDig) begin
						accum_d  = VALUE_W'(mac);
						digits_d = digits_q + 1'b1;
					end
				end else begin
					fields_d = '0;
					digits_d = '0;
					accum_d  = '0;
				end
			end
			default: begin
				fields_d = '0;
				digits_d = '0;
				accum_d  = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fields_q <= '0;
			digits_q <= '0;
			accum_q  <= '0;
		end else if (step) begin
			state_q  <= state_d;
			fields_q <= fields_d;
			digits_q <= digits_d;
			accum_q  <= accum_d;
		end
	end

	// field store has no reset; entries are read only after being written
	always_ff @(posedge clk) begin
		if (step && store_we) store_q[fields_q] <= accum_q;
	end

	// 'T' may close the fifth field straight from the accumulator
	always_comb begin
		result.value_a     = store_q[0];
		result.value_b     = store_q[1];
		result.value_c     = store_q[2];
		result.value_d     = store_q[3];
		result.value_e     = (fields_q == FIELDS_FULL) ? store_q[4] : accum_q;
		result.field_total = TOTAL_W'(result.value_a) + TOTAL_W'(result.value_b)
			+ TOTAL_W'(result.value_c) + TOTAL_W'(result.value_d)
			+ TOTAL_W'(result.value_e);
	end

	assign stat.emit         = valid && emit;
	assign stat.in_frame     = state_q == ST_FRAME;
	assign stat.fields_taken = fields_q;

endmodule

[src/fdp_out_reg.sv]
// Result register for the master stream side.
module fdp_out_reg
	import fdp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  result_t                result,
	output logic                   free,
	output logic                   tvalid,
	input  logic                   tready,
	output logic [OUT_TDATA_W-1:0] tdata
);

	logic    valid_q;
	result_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) data_q <= result;
	end

	assign free   = !valid_q || tready;
	assign tvalid = valid_q;
	assign tdata  = {1'b0, data_q.field_total, data_q.value_e, data_q.value_d,
		data_q.value_c, data_q.value_b, data_q.value_a};

endmodule

[src/framed_decimal_field_parser.sv]
// Framed decimal field parser, top level.
// Slave stream: one received ASCII byte per request on s_axis_tdata.
// Master stream: one request per completed frame 'S' v,v,v,v,v 'T' carrying
// the five field values and their sum.
// Bytes outside a frame other than 'S' are dropped; inside a frame digits
// build the current field (up to MAX_DIGITS, extra ones dropped), ',' closes
// a non-empty field, 'T' ends the frame, anything else aborts it.
// Throughput: one byte per cycle while no closing 'T' waits for the result register;
// the parser state updates once per byte in a single register stage.
// Path: the result for a closing 'T' reaches m_axis through the input register,
// then the result register, which loads as that byte leaves the input register.
// Stall: while a result waits on m_axis_tready, bytes that produce no result
// keep flowing; only a second closing 'T' waits in the input register.
// Reset (arst_n low) returns to idle outside any frame and drops any pending
// byte or result.
module framed_decimal_field_parser
	import fdp_pkg::*;
#(
	parameter int MAX_DIGITS = 3
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] rx_byte
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [9:0] value_a, [19:10] value_b, [29:20] value_c, [39:30] value_d,
	// [49:40] value_e, [62:50] field_total, [63] zero
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance_s1;
	logic       out_free;
	result_t    result;
	core_stat_t stat;

	assign advance_s1    = valid_s1 && (!stat.emit || out_free);
	assign s_axis_tready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) byte_s1 <= s_axis_tdata;
	end

	fdp_core #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (valid_s1),
		.step   (advance_s1),
		.rx_byte(byte_s1),
		.result (result),
		.stat   (stat)
	);

	fdp_out_reg u_out (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (advance_s1 && stat.emit),
		.result(result),
		.free  (out_free),
		.tvalid(m_axis_tvalid),
		.tready(m_axis_tready),
		.tdata (m_axis_tdata)
	);

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance_s1 && stat.emit && m_axis_tvalid && !m_axis_tready))
		else $error("result register overwritten while stalled");

	a_fields_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.fields_taken <= FIELDS_FULL)
		else $error("field count beyond five");

	a_emit_cause: assert property (@(posedge clk) disable iff (!arst_n)
		stat.emit |-> (stat.in_frame && byte_s1 == CH_END))
		else $error("result raised without closing byte in frame");

	a_total_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[62:50] == 13'(m_axis_tdata[9:0])
			+ 13'(m_axis_tdata[19:10]) + 13'(m_axis_tdata[29:20])
			+ 13'(m_axis_tdata[39:30]) + 13'(m_axis_tdata[49:40])))
		else $error("field total does not match field values");
`endif

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// Stream testbench for the framed decimal field parser: directed and random byte frames.
module tb_top;
	import fdp_pkg::*;

	localparam int DIGIT_LIMIT = 3;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	logic [7:0] rx_bytes_q[$];
	result_t    frames_due_q[$];
	int         send_idle_pct = 23;
	int         recv_idle_pct = 60;
	int         err_count     = 0;
	int         item_count    = 0;

	// shadow of the parser state
	logic              frame_open = 1'b0;
	logic [FCNT_W-1:0] n_fields   = '0;
	logic [DCNT_W-1:0] n_digits   = '0;
	logic [VALUE_W-1:0] acc       = '0;
	logic [VALUE_W-1:0] field_vals[NUM_FIELDS];

	framed_decimal_field_parser i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic void drop_frame();
		frame_open = 1'b0;
		n_fields   = '0;
		n_digits   = '0;
		acc        = '0;
	endfunction

	function automatic void close_field();
		if (n_digits != 0 && n_fields < FIELDS_FULL) begin
			field_vals[n_fields] = acc;
			n_fields = n_fields + 1'b1;
			n_digits = '0;
			acc      = '0;
		end
	endfunction

	function automatic void parse_byte(input logic [7:0] b);
		result_t r;
		int      sum;
		if (!frame_open) begin
			if (b == CH_START) begin
				drop_frame();
				frame_open = 1'b1;
			end
		end else if (b == CH_END) begin
			close_field();
			if (n_fields == FIELDS_FULL) begin
				r.value_a = field_vals[0];
				r.value_b = field_vals[1];
				r.value_c = field_vals[2];
				r.value_d = field_vals[3];
				r.value_e = field_vals[4];
				sum = 0;
				for (int k = 0; k < NUM_FIELDS; k++)
					sum += field_vals[k];
				r.field_total = TOTAL_W'(sum);
				frames_due_q.push_back(r);
			end
			drop_frame();
		end else if (b == CH_SEP) begin
			close_field();
		end else if (b >= CH_ZERO && b <= CH_NINE) begin
			if (n_digits < DIGIT_LIMIT) begin
				acc      = VALUE_W'(int'(acc) * 10 + int'(b - CH_ZERO));
				n_digits = n_digits + 1'b1;
			end
		end else begin
			drop_frame();
		end
	endfunction

	function automatic void cmp(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			err_count++;
		end
	endfunction

	function automatic void check_result(input logic [OUT_TDATA_W-1:0] d);
		result_t want;
		if (frames_due_q.size() == 0) begin
			$error("result with none expected: %h", d);
			err_count++;
		end else begin
			want = frames_due_q.pop_front();
			cmp("value_a", want.value_a, d[0 +: VALUE_W]);
			cmp("value_b", want.value_b, d[VALUE_W +: VALUE_W]);
			cmp("value_c", want.value_c, d[2*VALUE_W +: VALUE_W]);
			cmp("value_d", want.value_d, d[3*VALUE_W +: VALUE_W]);
			cmp("value_e", want.value_e, d[4*VALUE_W +: VALUE_W]);
			cmp("field_total", want.field_total, d[5*VALUE_W +: TOTAL_W]);
		end
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				parse_byte(s_axis_tdata);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (rx_bytes_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= rx_bytes_q.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_result(m_axis_tdata);
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic put(input logic [7:0] b);
		rx_bytes_q.push_back(b);
		item_count++;
	endtask

	task automatic put_digit(input int d);
		put(CH_ZERO + 8'(d));
	endtask

	function automatic logic [7:0] junk_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (b == CH_END || b == CH_SEP || (b >= CH_ZERO && b <= CH_NINE));
		return b;
	endfunction

	task automatic add_digits(input int n);
		int style;
		style = $urandom_range(7);
		repeat (n) begin
			if (style == 0)
				put_digit(9);
			else if (style == 1)
				put_digit(0);
			else
				put_digit($urandom_range(9));
		end
	endtask

	task automatic add_frame();
		int kind;
		int n_f;
		kind = $urandom_range(9);
		if (kind == 7)
			n_f = $urandom_range(4);
		else if (kind == 8)
			n_f = $urandom_range(5);
		else if (kind == 9)
			n_f = 6;
		else
			n_f = 5;
		put(CH_START);
		for (int k = 0; k < n_f; k++) begin
			if (k > 0) begin
				put(CH_SEP);
				if ($urandom_range(19) == 0)
					put(CH_SEP);
			end
			add_digits($urandom_range(1, DIGIT_LIMIT) + ($urandom_range(19) == 0));
		end
		if (kind == 8) begin
			put(junk_byte());
		end else begin
			if ($urandom_range(9) == 0) begin
				put(CH_SEP);
				add_digits($urandom_range(DIGIT_LIMIT));
			end
			put(CH_END);
		end
	endtask

	task automatic run_phase(input int s_pct, input int r_pct, input int upto);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		while (item_count < upto) begin
			repeat ($urandom_range(2))
				put(8'($urandom_range(255)));
			add_frame();
		end
		while (rx_bytes_q.size() != 0 || s_axis_tvalid || frames_due_q.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// idle bytes, then a frame with an overlong field, an empty field,
		// a comma after five fields and digits pending at the end
		put(8'h00);
		put(8'hFF);
		put(CH_START);
		repeat (4) put_digit(9);
		put(CH_SEP);
		put(CH_SEP);
		put_digit(0);
		put(CH_SEP);
		put_digit(1);
		put(CH_SEP);
		put_digit(2);
		put(CH_SEP);
		put_digit(3);
		put(CH_SEP);
		put_digit(4);
		put(CH_SEP);
		put_digit(5);
		put(CH_END);
		// second start aborts, short frame, abort by a stray byte
		put(CH_START);
		put_digit(1);
		put(CH_START);
		put(CH_START);
		put(CH_END);
		put(CH_START);
		put(8'h80);

		run_phase(23, 60, 290);
		run_phase(60, 23, 570);
		run_phase(0, 0, 850);

		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#400000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
